FILE: rtl/mlbs_pkg.sv
package mlbs_pkg;

  typedef enum logic [3:0] {
    ST_SEND_PROBE,
    ST_WAIT_PROBE,
    ST_SEND_MODE,
    ST_WAIT_MODE,
    ST_SEND_JOIN,
    ST_WAIT_JOIN,
    ST_SEND_CONNECT,
    ST_WAIT_CONNECT,
    ST_IDLE,
    ST_SEND_REQUEST,
    ST_WAIT_PROMPT,
    ST_WAIT_SEND_OK
  } seq_state_t;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_RESET_PROBE,
    CMD_MODE,
    CMD_JOIN,
    CMD_CONNECT,
    CMD_SEND_REQUEST,
    CMD_PAYLOAD
  } cmd_t;

  localparam logic [2:0] REG_HANDSHAKE_TIMEOUT = 3'd0;
  localparam logic [2:0] REG_JOIN_TIMEOUT      = 3'd1;
  localparam logic [2:0] REG_CONNECT_TIMEOUT   = 3'd2;
  localparam logic [2:0] REG_SEND_TIMEOUT      = 3'd3;
  localparam logic [2:0] REG_REPORT_PERIOD     = 3'd4;
  localparam logic [2:0] REG_MAX_FAILURES      = 3'd5;

  localparam logic [15:0] HANDSHAKE_TIMEOUT_RST = 16'd1000;
  localparam logic [15:0] JOIN_TIMEOUT_RST      = 16'd20000;
  localparam logic [15:0] CONNECT_TIMEOUT_RST   = 16'd5000;
  localparam logic [15:0] SEND_TIMEOUT_RST      = 16'd5000;
  localparam logic [15:0] REPORT_PERIOD_RST     = 16'd5000;
  localparam logic [3:0]  MAX_FAILURES_RST      = 4'd3;
  localparam logic [3:0]  FAIL_COUNT_MAX        = 4'd15;

endpackage

FILE: rtl/modem_link_bringup_sequencer_top.sv
// Channel   Handshake                 Payload
// in_       in_valid / in_ready       now_ms, reply_valid, token flags, tx_ready
// out_      out_valid / out_ready     command_issued, sequencer_state,
//                                     failures_now, link_restart
// config    psel/penable/pwrite       paddr, pwdata, prdata (pready tied high)
//
// One transaction per cycle while in_ready is high; the result is registered.
// The sequencer state and times update in the cycle a transaction is taken.
// in_ready is low only while a result is held and out_ready is low.
// Reset is synchronous and active low; all but result data regs take defaults.
module modem_link_bringup_sequencer_top #(
  parameter int TIME_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_now_ms,
  input  logic        in_reply_valid,
  input  logic        in_has_ok,
  input  logic        in_has_got_ip,
  input  logic        in_has_connect,
  input  logic        in_has_prompt,
  input  logic        in_has_send_ok,
  input  logic        in_has_link_lost,
  input  logic        in_tx_ready,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_command_issued,
  output logic [3:0]  out_sequencer_state,
  output logic [3:0]  out_failures_now,
  output logic        out_link_restart,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import mlbs_pkg::*;

  logic [15:0] hs_timeout_r;
  logic [15:0] join_timeout_r;
  logic [15:0] conn_timeout_r;
  logic [15:0] send_timeout_r;
  logic [15:0] report_period_r;
  logic [3:0]  max_fail_r;

  seq_state_t            state_r, state_nxt;
  logic [TIME_WIDTH-1:0] wait_start_r, wait_start_nxt;
  logic [TIME_WIDTH-1:0] last_report_r, last_report_nxt;
  logic [3:0]            fail_r, fail_nxt;

  logic       out_valid_r;
  cmd_t       cmd_r, cmd_nxt;
  seq_state_t out_state_r;
  logic [3:0] out_fail_r;
  logic       restart_r, restart_nxt;

  logic                  accept;
  logic                  cfg_write;
  logic [2:0]            reg_idx;
  logic [TIME_WIDTH-1:0] now_t;
  logic [TIME_WIDTH-1:0] wait_elapsed;
  logic [TIME_WIDTH-1:0] report_elapsed;
  logic                  msg;
  logic                  lost;
  seq_state_t            cur_state;
  logic [3:0]            cur_fail;
  logic [3:0]            fail_inc;
  logic                  fail_hit;
  logic                  hs_expired;
  logic                  join_expired;
  logic                  conn_expired;
  logic                  send_expired;
  logic                  report_due;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[4:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_timeout_r    <= HANDSHAKE_TIMEOUT_RST;
      join_timeout_r  <= JOIN_TIMEOUT_RST;
      conn_timeout_r  <= CONNECT_TIMEOUT_RST;
      send_timeout_r  <= SEND_TIMEOUT_RST;
      report_period_r <= REPORT_PERIOD_RST;
      max_fail_r      <= MAX_FAILURES_RST;
    end else if (cfg_write) begin
      case (reg_idx)
        REG_HANDSHAKE_TIMEOUT: hs_timeout_r    <= pwdata[15:0];
        REG_JOIN_TIMEOUT:      join_timeout_r  <= pwdata[15:0];
        REG_CONNECT_TIMEOUT:   conn_timeout_r  <= pwdata[15:0];
        REG_SEND_TIMEOUT:      send_timeout_r  <= pwdata[15:0];
        REG_REPORT_PERIOD:     report_period_r <= pwdata[15:0];
        REG_MAX_FAILURES:      max_fail_r      <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_HANDSHAKE_TIMEOUT: prdata = {16'd0, hs_timeout_r};
      REG_JOIN_TIMEOUT:      prdata = {16'd0, join_timeout_r};
      REG_CONNECT_TIMEOUT:   prdata = {16'd0, conn_timeout_r};
      REG_SEND_TIMEOUT:      prdata = {16'd0, send_timeout_r};
      REG_REPORT_PERIOD:     prdata = {16'd0, report_period_r};
      REG_MAX_FAILURES:      prdata = {28'd0, max_fail_r};
      default:               prdata = 32'd0;
    endcase
  end

  assign in_ready = !out_valid_r || out_ready;
  assign accept   = in_valid && in_ready;

  assign now_t          = TIME_WIDTH'(in_now_ms);
  assign wait_elapsed   = now_t - wait_start_r;
  assign report_elapsed = now_t - last_report_r;
  assign hs_expired     = wait_elapsed > TIME_WIDTH'(hs_timeout_r);
  assign join_expired   = wait_elapsed > TIME_WIDTH'(join_timeout_r);
  assign conn_expired   = wait_elapsed > TIME_WIDTH'(conn_timeout_r);
  assign send_expired   = wait_elapsed > TIME_WIDTH'(send_timeout_r);
  assign report_due     = report_elapsed >= TIME_WIDTH'(report_period_r);

  // A lost link clears the sequencer before the current state is evaluated.
  assign lost      = in_reply_valid && in_has_link_lost;
  assign msg       = in_reply_valid && !in_has_link_lost;
  assign cur_state = lost ? ST_SEND_PROBE : state_r;
  assign cur_fail  = lost ? 4'd0 : fail_r;
  assign fail_inc  = (cur_fail == FAIL_COUNT_MAX) ? FAIL_COUNT_MAX : cur_fail + 4'd1;
  assign fail_hit  = fail_inc >= max_fail_r;

  always_comb begin
    state_nxt       = cur_state;
    wait_start_nxt  = wait_start_r;
    last_report_nxt = last_report_r;
    fail_nxt        = cur_fail;
    cmd_nxt         = CMD_NONE;
    restart_nxt     = lost;
    case (cur_state)
      ST_SEND_PROBE, ST_SEND_MODE, ST_SEND_JOIN, ST_SEND_CONNECT, ST_SEND_REQUEST: begin
        if (in_tx_ready) begin
          case (cur_state)
            ST_SEND_PROBE:   cmd_nxt = CMD_RESET_PROBE;
            ST_SEND_MODE:    cmd_nxt = CMD_MODE;
            ST_SEND_JOIN:    cmd_nxt = CMD_JOIN;
            ST_SEND_CONNECT: cmd_nxt = CMD_CONNECT;
            default:         cmd_nxt = CMD_SEND_REQUEST;
          endcase
          state_nxt      = seq_state_t'(cur_state + 4'd1);
          wait_start_nxt = now_t;
        end
      end
      ST_WAIT_PROBE, ST_WAIT_MODE: begin
        if (msg && in_has_ok) begin
          state_nxt = seq_state_t'(cur_state + 4'd1);
        end else if (hs_expired) begin
          state_nxt = seq_state_t'(cur_state - 4'd1);
        end
      end
      ST_WAIT_JOIN: begin
        if (msg && in_has_got_ip) begin
          state_nxt = ST_SEND_CONNECT;
          fail_nxt  = 4'd0;
        end else if (join_expired) begin
          state_nxt = fail_hit ? ST_SEND_PROBE : ST_SEND_JOIN;
          fail_nxt  = fail_hit ? 4'd0 : fail_inc;
        end
      end
      ST_WAIT_CONNECT: begin
        if (msg && (in_has_connect || in_has_ok)) begin
          state_nxt       = ST_IDLE;
          fail_nxt        = 4'd0;
          last_report_nxt = now_t;
        end else if (conn_expired) begin
          state_nxt = fail_hit ? ST_SEND_JOIN : ST_SEND_CONNECT;
          fail_nxt  = fail_hit ? 4'd0 : fail_inc;
        end
      end
      ST_IDLE: begin
        if (report_due) begin
          last_report_nxt = now_t;
          state_nxt       = ST_SEND_REQUEST;
        end
      end
      ST_WAIT_PROMPT: begin
        if (msg && in_has_prompt) begin
          if (in_tx_ready) begin
            cmd_nxt        = CMD_PAYLOAD;
            state_nxt      = ST_WAIT_SEND_OK;
            wait_start_nxt = now_t;
          end
        end else if (send_expired) begin
          state_nxt = fail_hit ? ST_SEND_CONNECT : ST_IDLE;
          fail_nxt  = fail_hit ? 4'd0 : fail_inc;
        end
      end
      ST_WAIT_SEND_OK: begin
        if (msg && in_has_send_ok) begin
          state_nxt = ST_IDLE;
          fail_nxt  = 4'd0;
        end else if (send_expired) begin
          state_nxt = fail_hit ? ST_SEND_CONNECT : ST_IDLE;
          fail_nxt  = fail_hit ? 4'd0 : fail_inc;
        end
      end
      default: begin
        state_nxt = ST_SEND_PROBE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_SEND_PROBE;
      wait_start_r  <= '0;
      last_report_r <= '0;
      fail_r        <= 4'd0;
    end else if (accept) begin
      state_r       <= state_nxt;
      wait_start_r  <= wait_start_nxt;
      last_report_r <= last_report_nxt;
      fail_r        <= fail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r       <= cmd_nxt;
      out_state_r <= state_nxt;
      out_fail_r  <= fail_nxt;
      restart_r   <= restart_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_command_issued  = cmd_r;
  assign out_sequencer_state = out_state_r;
  assign out_failures_now    = out_fail_r;
  assign out_link_restart    = restart_r;

  a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r && out_state_r == state_r && out_fail_r == fail_r)
    else $error("Accepted transaction did not produce a matching result.");

  a_restart_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && restart_r |->
      (out_state_r == ST_SEND_PROBE || out_state_r == ST_WAIT_PROBE) && out_fail_r == 4'd0)
    else $error("Link restart left the sequencer away from the start.");

  a_payload_waits_confirm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && cmd_r == CMD_PAYLOAD |-> out_state_r == ST_WAIT_SEND_OK)
    else $error("Payload issued without moving to the send confirmation wait.");

  a_command_moves_state: assert property (@(posedge clk) disable iff (!rst_n)
    accept && cmd_nxt != CMD_NONE |-> state_nxt != cur_state)
    else $error("Command issued without a state change.");

  a_state_only_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
    !accept |=> $stable(state_r) && $stable(fail_r))
    else $error("Sequencer state changed without a transaction.");

endmodule

FILE: bench/testbench.sv
module testbench;
  import mlbs_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int PHASE_POLLS = 400;

  typedef struct packed {
    logic [31:0] now;
    logic        reply;
    logic        ok;
    logic        got_ip;
    logic        conn;
    logic        prompt;
    logic        send_ok;
    logic        lost;
    logic        tx;
  } poll_t;

  typedef struct packed {
    cmd_t       cmd;
    seq_state_t st;
    logic [3:0] fails;
    logic       restart;
  } report_t;

  // Flags are reply, ok, got_ip, connect, prompt, send_ok, link_lost, tx_ready.
  typedef struct packed {
    logic [31:0] now;
    logic [7:0]  flags;
    logic        known;
    report_t     want;
  } script_row_t;

  localparam report_t NO_REPORT = '{CMD_NONE, ST_SEND_PROBE, 4'd0, 1'b0};

  localparam script_row_t SCRIPT [26] = '{
    '{32'd0,          8'b0000_0000, 1'b1, '{CMD_NONE, ST_SEND_PROBE, 4'd0, 1'b0}},
    '{32'd10,         8'b0000_0001, 1'b1, '{CMD_RESET_PROBE, ST_WAIT_PROBE, 4'd0, 1'b0}},
    '{32'd1010,       8'b0000_0000, 1'b0, NO_REPORT},
    '{32'd1011,       8'b0000_0000, 1'b0, NO_REPORT},
    '{32'hFFFF_FF00,  8'b0000_0001, 1'b0, NO_REPORT},
    '{32'h0000_02E7,  8'b1011_1100, 1'b0, NO_REPORT},
    '{32'h0000_02E8,  8'b1100_0000, 1'b0, NO_REPORT},
    '{32'h0000_0300,  8'b0000_0001, 1'b0, NO_REPORT},
    '{32'h0000_0301,  8'b0100_0000, 1'b0, NO_REPORT},
    '{32'h0000_0302,  8'b1100_0000, 1'b0, NO_REPORT},
    '{32'h0000_0400,  8'b0000_0001, 1'b0, NO_REPORT},
    '{32'd21025,      8'b0000_0000, 1'b0, NO_REPORT},
    '{32'd21100,      8'b0000_0001, 1'b0, NO_REPORT},
    '{32'd21200,      8'b1010_0000, 1'b0, NO_REPORT},
    '{32'd21300,      8'b0000_0001, 1'b0, NO_REPORT},
    '{32'd26301,      8'b0000_0000, 1'b0, NO_REPORT},
    '{32'd26400,      8'b0000_0001, 1'b0, NO_REPORT},
    '{32'd26500,      8'b1100_0000, 1'b0, NO_REPORT},
    '{32'd31499,      8'b0000_0000, 1'b0, NO_REPORT},
    '{32'd31500,      8'b0000_0000, 1'b0, NO_REPORT},
    '{32'd31600,      8'b0000_0001, 1'b0, NO_REPORT},
    '{32'hFFFF_FFFF,  8'b1000_1000, 1'b0, NO_REPORT},
    '{32'hFFFF_FFFF,  8'b1000_1001, 1'b0, NO_REPORT},
    '{32'd0,          8'b1000_0100, 1'b0, NO_REPORT},
    '{32'd5,          8'b1000_0011, 1'b1, '{CMD_RESET_PROBE, ST_WAIT_PROBE, 4'd0, 1'b1}},
    '{32'd6,          8'b1100_0010, 1'b1, '{CMD_NONE, ST_SEND_PROBE, 4'd0, 1'b1}}
  };

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_now_ms;
  logic        in_reply_valid;
  logic        in_has_ok;
  logic        in_has_got_ip;
  logic        in_has_connect;
  logic        in_has_prompt;
  logic        in_has_send_ok;
  logic        in_has_link_lost;
  logic        in_tx_ready;
  logic        out_valid;
  logic        out_ready;
  logic [2:0]  out_command_issued;
  logic [3:0]  out_sequencer_state;
  logic [3:0]  out_failures_now;
  logic        out_link_restart;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  modem_link_bringup_sequencer_top dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_now_ms           (in_now_ms),
    .in_reply_valid      (in_reply_valid),
    .in_has_ok           (in_has_ok),
    .in_has_got_ip       (in_has_got_ip),
    .in_has_connect      (in_has_connect),
    .in_has_prompt       (in_has_prompt),
    .in_has_send_ok      (in_has_send_ok),
    .in_has_link_lost    (in_has_link_lost),
    .in_tx_ready         (in_tx_ready),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_command_issued  (out_command_issued),
    .out_sequencer_state (out_sequencer_state),
    .out_failures_now    (out_failures_now),
    .out_link_restart    (out_link_restart),
    .psel                (psel),
    .penable             (penable),
    .pwrite              (pwrite),
    .paddr               (paddr),
    .pwdata              (pwdata),
    .prdata              (prdata),
    .pready              (pready)
  );

  // Predicted sequencer state and register copies.
  logic [15:0] hs_to       = HANDSHAKE_TIMEOUT_RST;
  logic [15:0] join_to     = JOIN_TIMEOUT_RST;
  logic [15:0] conn_to     = CONNECT_TIMEOUT_RST;
  logic [15:0] send_to     = SEND_TIMEOUT_RST;
  logic [15:0] period      = REPORT_PERIOD_RST;
  logic [3:0]  fail_limit  = MAX_FAILURES_RST;
  seq_state_t  seq_st      = ST_SEND_PROBE;
  logic [31:0] wait_start  = '0;
  logic [31:0] last_report = '0;
  logic [3:0]  fail_cnt    = '0;

  report_t     pending_reports[$];
  logic [31:0] poll_ms = '0;
  int          errors = 0;
  int          polls_sent = 0;
  int          reports_checked = 0;
  int          payloads_seen = 0;
  int          restarts_seen = 0;
  int          fallbacks_seen = 0;
  int          feed_gap_pct = 0;
  int          sink_stall_pct = 0;
  int          quiet_cycles = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic fail_limit_hit();
    if (fail_cnt != FAIL_COUNT_MAX) fail_cnt++;
    if (fail_cnt >= fail_limit) begin
      fail_cnt = '0;
      fallbacks_seen++;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic step_sequencer(input poll_t p, output report_t r);
    logic        msg;
    logic [31:0] since_start;
    logic [31:0] since_report;
    msg = p.reply;
    r.cmd = CMD_NONE;
    r.restart = 1'b0;
    if (p.reply && p.lost) begin
      seq_st = ST_SEND_PROBE;
      fail_cnt = '0;
      msg = 1'b0;
      r.restart = 1'b1;
      restarts_seen++;
    end
    since_start = p.now - wait_start;
    since_report = p.now - last_report;
    case (seq_st)
      ST_SEND_PROBE: if (p.tx) begin
        r.cmd = CMD_RESET_PROBE;
        seq_st = ST_WAIT_PROBE;
        wait_start = p.now;
      end
      ST_SEND_MODE: if (p.tx) begin
        r.cmd = CMD_MODE;
        seq_st = ST_WAIT_MODE;
        wait_start = p.now;
      end
      ST_SEND_JOIN: if (p.tx) begin
        r.cmd = CMD_JOIN;
        seq_st = ST_WAIT_JOIN;
        wait_start = p.now;
      end
      ST_SEND_CONNECT: if (p.tx) begin
        r.cmd = CMD_CONNECT;
        seq_st = ST_WAIT_CONNECT;
        wait_start = p.now;
      end
      ST_SEND_REQUEST: if (p.tx) begin
        r.cmd = CMD_SEND_REQUEST;
        seq_st = ST_WAIT_PROMPT;
        wait_start = p.now;
      end
      ST_WAIT_PROBE: begin
        if (msg && p.ok) seq_st = ST_SEND_MODE;
        else if (since_start > 32'(hs_to)) seq_st = ST_SEND_PROBE;
      end
      ST_WAIT_MODE: begin
        if (msg && p.ok) seq_st = ST_SEND_JOIN;
        else if (since_start > 32'(hs_to)) seq_st = ST_SEND_MODE;
      end
      ST_WAIT_JOIN: begin
        if (msg && p.got_ip) begin
          seq_st = ST_SEND_CONNECT;
          fail_cnt = '0;
        end else if (since_start > 32'(join_to)) begin
          seq_st = fail_limit_hit() ? ST_SEND_PROBE : ST_SEND_JOIN;
        end
      end
      ST_WAIT_CONNECT: begin
        if (msg && (p.conn || p.ok)) begin
          seq_st = ST_IDLE;
          fail_cnt = '0;
          last_report = p.now;
        end else if (since_start > 32'(conn_to)) begin
          seq_st = fail_limit_hit() ? ST_SEND_JOIN : ST_SEND_CONNECT;
        end
      end
      ST_IDLE: begin
        if (since_report >= 32'(period)) begin
          last_report = p.now;
          seq_st = ST_SEND_REQUEST;
        end
      end
      ST_WAIT_PROMPT: begin
        if (msg && p.prompt) begin
          if (p.tx) begin
            r.cmd = CMD_PAYLOAD;
            seq_st = ST_WAIT_SEND_OK;
            wait_start = p.now;
            payloads_seen++;
          end
        end else if (since_start > 32'(send_to)) begin
          seq_st = fail_limit_hit() ? ST_SEND_CONNECT : ST_IDLE;
        end
      end
      ST_WAIT_SEND_OK: begin
        if (msg && p.send_ok) begin
          seq_st = ST_IDLE;
          fail_cnt = '0;
        end else if (since_start > 32'(send_to)) begin
          seq_st = fail_limit_hit() ? ST_SEND_CONNECT : ST_IDLE;
        end
      end
      default: seq_st = ST_SEND_PROBE;
    endcase
    r.st = seq_st;
    r.fails = fail_cnt;
  endtask

  // Mostly replies that fit the current wait, plus timeouts at their boundary,
  // link losses and plain noise.
  task automatic compose_poll(output poll_t p);
    int          pick;
    int          k;
    logic        want;
    logic [15:0] lim;
    p = '0;
    p.now = poll_ms + 32'($urandom_range(0, 20));
    pick = $urandom_range(0, 99);
    k = $urandom_range(0, 9);
    want = (k < 6);
    if (pick < 3) begin
      {p.ok, p.got_ip, p.conn, p.prompt, p.send_ok, p.tx} = 6'($urandom);
      p.reply = 1'b1;
      p.lost = 1'b1;
    end else if (pick < 11) begin
      {p.reply, p.ok, p.got_ip, p.conn, p.prompt, p.send_ok, p.lost, p.tx} = 8'($urandom);
      if (pick < 5) p.now = $urandom();
    end else begin
      case (seq_st)
        ST_SEND_PROBE, ST_SEND_MODE, ST_SEND_JOIN, ST_SEND_CONNECT, ST_SEND_REQUEST: begin
          p.tx = (k != 0);
        end
        ST_IDLE: begin
          if (k < 4) p.now = last_report + 32'(period) - 32'($urandom_range(0, 1));
        end
        default: begin
          case (seq_st)
            ST_WAIT_PROBE, ST_WAIT_MODE: lim = hs_to;
            ST_WAIT_JOIN:                lim = join_to;
            ST_WAIT_CONNECT:             lim = conn_to;
            default:                     lim = send_to;
          endcase
          {p.ok, p.got_ip, p.conn, p.prompt, p.send_ok} = 5'($urandom);
          p.tx = ($urandom_range(0, 3) != 0);
          p.reply = want ? 1'b1 : 1'($urandom_range(0, 1));
          case (seq_st)
            ST_WAIT_PROBE, ST_WAIT_MODE: p.ok = want;
            ST_WAIT_JOIN: p.got_ip = want;
            ST_WAIT_CONNECT: begin
              p.conn = want & 1'($urandom_range(0, 1));
              p.ok = want ? (p.ok | !p.conn) : 1'b0;
            end
            ST_WAIT_PROMPT: p.prompt = want;
            default: p.send_ok = want;
          endcase
          if (!want && k < 8) p.now = wait_start + 32'(lim) + 32'($urandom_range(0, 2));
        end
      endcase
    end
    poll_ms = p.now;
  endtask

  task automatic offer_poll(input poll_t p, input logic known, input report_t want);
    int      gap;
    report_t r;
    if (feed_gap_pct != 0 && $urandom_range(0, 99) < feed_gap_pct) begin
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_now_ms        <= p.now;
    in_reply_valid   <= p.reply;
    in_has_ok        <= p.ok;
    in_has_got_ip    <= p.got_ip;
    in_has_connect   <= p.conn;
    in_has_prompt    <= p.prompt;
    in_has_send_ok   <= p.send_ok;
    in_has_link_lost <= p.lost;
    in_tx_ready      <= p.tx;
    in_valid         <= 1'b1;
    do @(posedge clk); while (!in_ready);
    step_sequencer(p, r);
    pending_reports.push_back(known ? want : r);
    polls_sent++;
    if (polls_sent % 64 == 0) begin
      case ($urandom_range(0, 2))
        0:       feed_gap_pct = 0;
        1:       feed_gap_pct = 10;
        default: feed_gap_pct = 40;
      endcase
    end
  endtask

  task automatic wait_for_reports();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_HANDSHAKE_TIMEOUT: hs_to = val[15:0];
      REG_JOIN_TIMEOUT:      join_to = val[15:0];
      REG_CONNECT_TIMEOUT:   conn_to = val[15:0];
      REG_SEND_TIMEOUT:      send_to = val[15:0];
      REG_REPORT_PERIOD:     period = val[15:0];
      REG_MAX_FAILURES:      fail_limit = val[3:0];
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic load_settings(input logic [15:0] hs, input logic [15:0] jn,
                               input logic [15:0] cn, input logic [15:0] sd,
                               input logic [15:0] per, input logic [3:0] mf);
    write_reg(REG_HANDSHAKE_TIMEOUT, 32'(hs));
    write_reg(REG_JOIN_TIMEOUT, 32'(jn));
    write_reg(REG_CONNECT_TIMEOUT, 32'(cn));
    write_reg(REG_SEND_TIMEOUT, 32'(sd));
    write_reg(REG_REPORT_PERIOD, 32'(per));
    write_reg(REG_MAX_FAILURES, 32'(mf));
  endtask

  initial begin : stimulus
    poll_t       p;
    script_row_t row;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_now_ms        = '0;
    in_reply_valid   = 1'b0;
    in_has_ok        = 1'b0;
    in_has_got_ip    = 1'b0;
    in_has_connect   = 1'b0;
    in_has_prompt    = 1'b0;
    in_has_send_ok   = 1'b0;
    in_has_link_lost = 1'b0;
    in_tx_ready      = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < 26; i++) begin
      row = SCRIPT[i];
      p.now = row.now;
      {p.reply, p.ok, p.got_ip, p.conn, p.prompt, p.send_ok, p.lost, p.tx} = row.flags;
      offer_poll(p, row.known, row.want);
    end
    poll_ms = p.now;

    for (int ph = 0; ph < 5; ph++) begin
      wait_for_reports();
      case (ph)
        0: load_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 4'd0);
        1: load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd15);
        2: load_settings(16'd40, 16'd200, 16'd90, 16'd60, 16'd120, 4'd1);
        3: load_settings(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                         16'($urandom), 4'($urandom_range(1, 15)));
        default: load_settings(HANDSHAKE_TIMEOUT_RST, JOIN_TIMEOUT_RST, CONNECT_TIMEOUT_RST,
                               SEND_TIMEOUT_RST, REPORT_PERIOD_RST, 4'd2);
      endcase
      for (int n = 0; n < PHASE_POLLS; n++) begin
        compose_poll(p);
        offer_poll(p, 1'b0, NO_REPORT);
      end
    end

    wait_for_reports();
    repeat (10) @(posedge clk);
    $display("Ran %0d polls over six register settings: %0d results checked,", polls_sent,
             reports_checked);
    $display("%0d payloads sent, %0d fall-backs and %0d link restarts predicted.",
             payloads_seen, fallbacks_seen, restarts_seen);
    if (errors == 0) begin
      $display("PASS modem_link_bringup_sequencer_top");
    end else begin
      $display("FAIL modem_link_bringup_sequencer_top");
    end
    $finish;
  end

  // The single long hold-off lets the output register fill and stall the input.
  initial begin : result_sink
    int hold_left;
    int stall_left;
    bit long_hold_done;
    hold_left = 0;
    stall_left = 0;
    long_hold_done = 1'b0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (!long_hold_done && reports_checked >= 900) begin
        long_hold_done = 1'b1;
        hold_left = 300;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (sink_stall_pct != 0 && $urandom_range(0, 99) < sink_stall_pct) begin
        stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : report_check
    report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_reports.size() == 0) begin
        $error("result transaction arrived with no expectation waiting");
        errors++;
      end else begin
        want = pending_reports.pop_front();
        if (out_command_issued !== want.cmd) begin
          $error("command_issued: expected %0d, got %0d", want.cmd, out_command_issued);
          errors++;
        end
        if (out_sequencer_state !== want.st) begin
          $error("sequencer_state: expected %0d, got %0d", want.st, out_sequencer_state);
          errors++;
        end
        if (out_failures_now !== want.fails) begin
          $error("failures_now: expected %0d, got %0d", want.fails, out_failures_now);
          errors++;
        end
        if (out_link_restart !== want.restart) begin
          $error("link_restart: expected %0d, got %0d", want.restart, out_link_restart);
          errors++;
        end
      end
      reports_checked++;
      if (reports_checked % 64 == 0) begin
        case ($urandom_range(0, 2))
          0:       sink_stall_pct = 0;
          1:       sink_stall_pct = 15;
          default: sink_stall_pct = 40;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Timed out after %0d cycles without a transaction.", quiet_cycles);
      $display("FAIL modem_link_bringup_sequencer_top");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
